FILE: hdl/gbts_pkg.sv
// gbts_pkg: shared constants for the gap buffer text store
// holds operation and status codes, field widths and stream word layout
// no dependencies
package gbts_pkg;

  // default store size in bytes
  localparam int unsigned DEFAULT_CAPACITY = 4096;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // input word layout: position, count, value from bit 0 up
  localparam int unsigned POS_LSB    = 0;
  localparam int unsigned CNT_LSB    = POS_LSB + POS_W;
  localparam int unsigned VAL_LSB    = CNT_LSB + CNT_W;
  localparam int unsigned IN_FIELDS  = VAL_LSB + BYTE_W;
  localparam int unsigned IN_DATA_W  = ((IN_FIELDS + 7) / 8) * 8;

  // output word layout: read byte, text length from bit 0 up
  localparam int unsigned RB_LSB     = 0;
  localparam int unsigned LEN_LSB    = RB_LSB + BYTE_W;
  localparam int unsigned OUT_FIELDS = LEN_LSB + LEN_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: hdl/gap_buffer_text_store_core.sv
// gap_buffer_text_store_core: byte text store kept as a gap buffer in one memory
// depends on gbts_pkg
//
// usage
//   slave channel takes one edit word per handshake: the operation code in
//   tuser, position, count and value in tdata. master channel returns one
//   result word per edit: read byte and text length in tdata, status in tuser.
// timing
//   an edit that moves the gap by d > 0 bytes copies the d bytes, waits for
//   the last write-back, sees the write-back done, does its edit step and
//   then loads its result. an edit that finds the gap in place skips the
//   copies. the gap copy runs one byte per cycle through the single
//   read/write pair of the byte memory, so d sets how long a move takes.
//   rejected edits and unknown codes go from acceptance straight to the
//   load of their result. the next word is taken in the cycle after the load; one edit
//   is worked on at a time.
// reset
//   the text is empty after reset; the memory itself is not cleared and
//   needs no clearing pass.
// stalls
//   the result sits in an output register; a new edit is taken while it
//   waits, and that edit holds in its last step until the register is free.
module gap_buffer_text_store_core #(
  parameter int unsigned CAPACITY = gbts_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // position [12:0], count [25:13], value [33:26], zero fill above
  input  logic [gbts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op [1:0]
  input  logic [gbts_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_byte [7:0], text_length [20:8], zero fill above
  output logic [gbts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status [1:0]
  output logic [gbts_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import gbts_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned LW = (PW > POS_W + 1) ? PW : POS_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_EDIT,
    S_FIN
  } state_e;

  state_e                state_q;
  logic [PW-1:0]         gs_q, ge_q, tgt_q, pos_q, cnt_q;
  logic [OP_W-1:0]       op_q;
  logic [BYTE_W-1:0]     val_q;
  logic                  far_q;
  logic [STATUS_W-1:0]   st_q;
  logic                  wr_pend_q;
  logic [AW-1:0]         wr_addr_q;
  logic                  m_valid_q;
  logic [BYTE_W-1:0]     m_rbyte_q;
  logic [LEN_W-1:0]      m_len_q;
  logic [STATUS_W-1:0]   m_st_q;
  logic                  out_load;

  // byte memory and its ports
  logic [BYTE_W-1:0]     mem_q [CAPACITY];
  logic [BYTE_W-1:0]     rdata_q;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  logic [BYTE_W-1:0]     mem_wdata;

  // input fields
  logic [POS_W-1:0]      pos_in;
  logic [CNT_W-1:0]      cnt_in;
  logic [BYTE_W-1:0]     val_in;
  assign pos_in = s_axis_tdata[POS_LSB +: POS_W];
  assign cnt_in = s_axis_tdata[CNT_LSB +: CNT_W];
  assign val_in = s_axis_tdata[VAL_LSB +: BYTE_W];

  // text length and range checks
  logic [LW-1:0]         len_w, pos_w, end_w, half_w, tgt_w;
  logic [STATUS_W-1:0]   st_in;
  logic                  go_in, far_in;
  logic                  accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign len_w  = LW'(gs_q) + LW'(CAPACITY) - LW'(ge_q);
  assign pos_w  = LW'(pos_in);
  assign end_w  = pos_w + LW'(cnt_in);
  assign half_w = pos_w + LW'(cnt_in >> 1);

  // result register can take a word this cycle
  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  // decode the incoming edit and pick where the gap has to go
  always_comb begin
    st_in  = STATUS_OK;
    go_in  = 1'b0;
    far_in = 1'b0;
    tgt_w  = '0;
    unique case (s_axis_tuser)
      OP_INSERT: begin
        if (pos_w > len_w) begin
          st_in = STATUS_RANGE;
        end else if (len_w >= LW'(CAPACITY)) begin
          st_in = STATUS_FULL;
        end else begin
          go_in = 1'b1;
          tgt_w = pos_w;
        end
      end
      OP_DELETE: begin
        if (end_w > len_w) begin
          st_in = STATUS_RANGE;
        end else begin
          go_in  = 1'b1;
          far_in = LW'(gs_q) < half_w;
          tgt_w  = far_in ? end_w : pos_w;
        end
      end
      OP_READ: begin
        if (pos_w >= len_w) begin
          st_in = STATUS_RANGE;
        end else begin
          go_in = 1'b1;
          tgt_w = pos_w + LW'(1);
        end
      end
      default: begin
        st_in = STATUS_OK;
      end
    endcase
  end

  // memory port control: copy reads in the move phase, edit access after
  always_comb begin
    mem_we    = wr_pend_q;
    mem_waddr = wr_addr_q;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_MOVE: begin
        if (gs_q > tgt_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(gs_q - PW'(1));
        end else if (gs_q < tgt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ge_q[AW-1:0];
        end
      end
      S_EDIT: begin
        if (op_q == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = gs_q[AW-1:0];
          mem_wdata = val_q;
        end else if (op_q == OP_READ) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q[AW-1:0];
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // byte memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // sequencer, gap pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      gs_q      <= '0;
      ge_q      <= PW'(CAPACITY);
      tgt_q     <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      op_q      <= OP_INSERT;
      val_q     <= '0;
      far_q     <= 1'b0;
      st_q      <= STATUS_OK;
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
      m_valid_q <= 1'b0;
      m_rbyte_q <= '0;
      m_len_q   <= '0;
      m_st_q    <= STATUS_OK;
    end else begin
      // a copied byte is written back the cycle after its read
      wr_pend_q <= (state_q == S_MOVE) && (gs_q != tgt_q);
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= s_axis_tuser;
            pos_q   <= PW'(pos_in);
            cnt_q   <= PW'(cnt_in);
            val_q   <= val_in;
            far_q   <= far_in;
            st_q    <= st_in;
            tgt_q   <= tgt_w[PW-1:0];
            state_q <= go_in ? S_MOVE : S_FIN;
          end
        end
        S_MOVE: begin
          // one byte across the gap per cycle, written back in the cycle after
          if (gs_q > tgt_q) begin
            gs_q      <= gs_q - PW'(1);
            ge_q      <= ge_q - PW'(1);
            wr_addr_q <= AW'(ge_q - PW'(1));
          end else if (gs_q < tgt_q) begin
            gs_q      <= gs_q + PW'(1);
            ge_q      <= ge_q + PW'(1);
            wr_addr_q <= gs_q[AW-1:0];
          end else if (!wr_pend_q) begin
            state_q <= S_EDIT;
          end
        end
        S_EDIT: begin
          if (op_q == OP_INSERT) begin
            gs_q <= gs_q + PW'(1);
          end else if (op_q == OP_DELETE) begin
            if (far_q) begin
              gs_q <= pos_q;
            end else begin
              ge_q <= ge_q + cnt_q;
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          // wait for a free result register
          if (out_load) begin
            m_rbyte_q <= (op_q == OP_READ && st_q == STATUS_OK) ? rdata_q : '0;
            m_len_q   <= len_w[LEN_W-1:0];
            m_st_q    <= st_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // stream outputs
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({m_len_q, m_rbyte_q});
  assign m_axis_tuser  = m_st_q;

endmodule

FILE: tb/tb_gap_buffer_text_store_core.sv
// tb_gap_buffer_text_store_core: self-checking bench for the gap buffer text store
// drives edit words into the slave stream and checks every result word against its own predictor
// depends on gbts_pkg and gap_buffer_text_store_core
module tb_gap_buffer_text_store_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gbts_pkg::*;

  localparam int unsigned CAP         = DEFAULT_CAPACITY;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_EDITS = 280;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // one predicted result word
  typedef struct {
    int unsigned         idx;
    logic [BYTE_W-1:0]   rb;
    logic [LEN_W-1:0]    len;
    logic [STATUS_W-1:0] st;
  } edit_result_t;

  // predictor of the text store plus the queue of results still owed
  class text_store_board;
    logic [BYTE_W-1:0] mem [CAP];
    int unsigned       gap_lo;
    int unsigned       gap_hi;
    edit_result_t      owed_q[$];
    int unsigned       edits_seen;
    int unsigned       results_seen;
    int unsigned       mismatches;
    int unsigned       peak_len;
    int unsigned       op_seen [4];

    function new();
      gap_lo = 0;
      gap_hi = CAP;
      edits_seen = 0;
      results_seen = 0;
      mismatches = 0;
      peak_len = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int unsigned text_len();
      return gap_lo + (CAP - gap_hi);
    endfunction

    // copy bytes across the gap until it starts at logical position to
    function void move_gap(int unsigned to);
      while (to < gap_lo) begin
        gap_lo--;
        gap_hi--;
        mem[gap_hi] = mem[gap_lo];
      end
      while (to > gap_lo) begin
        mem[gap_lo] = mem[gap_hi];
        gap_lo++;
        gap_hi++;
      end
    endfunction

    // apply an accepted edit and queue the result it should give
    function void note_edit(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [CNT_W-1:0] cnt, logic [BYTE_W-1:0] val);
      int unsigned  len;
      int unsigned  p;
      int unsigned  c;
      edit_result_t r;
      len = text_len();
      p = pos;
      c = cnt;
      r.idx = edits_seen;
      r.rb = '0;
      r.st = STATUS_OK;
      case (op)
        OP_INSERT: begin
          if (p > len) r.st = STATUS_RANGE;
          else if (len >= CAP) r.st = STATUS_FULL;
          else begin
            move_gap(p);
            mem[gap_lo] = val;
            gap_lo++;
          end
        end
        OP_DELETE: begin
          if (p + c > len) r.st = STATUS_RANGE;
          else if (gap_lo < p + c / 2) begin
            move_gap(p + c);
            gap_lo = p;
          end else begin
            move_gap(p);
            gap_hi += c;
          end
        end
        OP_READ: begin
          if (p >= len) r.st = STATUS_RANGE;
          else begin
            move_gap(p + 1);
            r.rb = mem[p];
          end
        end
        default: ;
      endcase
      r.len = LEN_W'(text_len());
      if (text_len() > peak_len) peak_len = text_len();
      op_seen[op]++;
      edits_seen++;
      owed_q.push_back(r);
    endfunction

    // compare a result word with the oldest one owed
    function void check_result(logic [BYTE_W-1:0] rb, logic [LEN_W-1:0] len,
                               logic [STATUS_W-1:0] st);
      edit_result_t e;
      results_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: byte %02h len %0d status %0d", rb, len, st);
        return;
      end
      e = owed_q.pop_front();
      if (rb !== e.rb || len !== e.len || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("edit %0d: expected byte %02h len %0d status %0d, %s %02h len %0d status %0d",
                   e.idx, e.rb, e.len, e.st, "got byte", rb, len, st);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  text_store_board board = new();
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_stall_pct = 0;
  int unsigned     hold_requests = 0;
  int unsigned     holds_done = 0;
  int unsigned     hold_left = 0;

  gap_buffer_text_store_core #(.CAPACITY(CAP)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side: check accepted words, then pick tready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[RB_LSB +: BYTE_W], m_axis_tdata[LEN_LSB +: LEN_W],
                         m_axis_tuser);
    if (holds_done != hold_requests) begin
      hold_left = HOLD_CYCLES;
      holds_done = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one edit word, with random idle cycles first, and wait for it to go
  task automatic send_edit(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [CNT_W-1:0] cnt, logic [BYTE_W-1:0] val);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[POS_LSB +: POS_W] = pos;
    word[CNT_LSB +: CNT_W] = cnt;
    word[VAL_LSB +: BYTE_W] = val;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_edit(op, pos, cnt, val);
  endtask

  // pause the sender until every owed result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk_i);
  endtask

  // one random edit, mostly well formed and close to the gap so moves stay short
  task automatic rand_edit();
    int unsigned len;
    int unsigned roll;
    int unsigned p;
    int unsigned c;
    int unsigned room;
    len = board.text_len();
    roll = $urandom_range(99);
    p = board.gap_lo + $urandom_range(8);
    p = (p >= 4) ? p - 4 : 0;
    if (p > len) p = len;
    if ($urandom_range(99) < 15) p = $urandom_range(len);
    if (roll < 8) begin
      // noise over the whole field ranges
      send_edit(OP_W'($urandom_range(3)), POS_W'($urandom_range(8191)),
                CNT_W'($urandom_range(8191)), BYTE_W'($urandom_range(255)));
    end else if (roll < 12) begin
      send_edit(OP_UNKNOWN, POS_W'($urandom_range(8191)), CNT_W'($urandom_range(8191)),
                BYTE_W'($urandom_range(255)));
    end else if (len < 3 || (roll < 50 && len < 160)) begin
      // just past the end now and then
      if (roll == 49) p = len + 1 + $urandom_range(3);
      send_edit(OP_INSERT, POS_W'(p), CNT_W'($urandom_range(8191)),
                BYTE_W'($urandom_range(255)));
    end else if (roll < 72) begin
      room = len - p;
      c = $urandom_range(room < 4 ? room : 4);
      // range running one past the text
      if (roll >= 70) c = room + 1;
      send_edit(OP_DELETE, POS_W'(p), CNT_W'(c), BYTE_W'($urandom_range(255)));
    end else begin
      if (p >= len) p = len - 1;
      if (roll >= 97) p = len;
      send_edit(OP_READ, POS_W'(p), CNT_W'($urandom_range(8191)),
                BYTE_W'($urandom_range(255)));
    end
  endtask

  // no-handshake watchdog
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned tx_mode [4];
    int unsigned rx_mode [4];
    tx_mode = '{0, 62, 0, 9};
    rx_mode = '{0, 0, 62, 9};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store cases
    send_edit(OP_READ, 0, 0, 8'h00);
    send_edit(OP_DELETE, 0, 0, 8'h00);
    send_edit(OP_DELETE, 0, 1, 8'h00);
    send_edit(OP_INSERT, 1, 0, 8'h11);
    // directed: build a short text with extreme bytes
    send_edit(OP_INSERT, 0, 0, 8'h00);
    send_edit(OP_INSERT, 1, 0, 8'hFF);
    send_edit(OP_INSERT, 1, 8191, 8'hA5);
    send_edit(OP_INSERT, 0, 0, 8'h5A);
    send_edit(OP_READ, 0, 0, 8'h00);
    send_edit(OP_READ, 3, 0, 8'h00);
    send_edit(OP_READ, 1, 0, 8'hFF);
    send_edit(OP_READ, 4, 0, 8'h00);
    send_edit(OP_READ, 8191, 8191, 8'hFF);
    send_edit(OP_UNKNOWN, 8191, 8191, 8'hFF);
    send_edit(OP_DELETE, 8191, 8191, 8'hFF);
    send_edit(OP_INSERT, 8191, 0, 8'h77);
    send_edit(OP_DELETE, 1, 2, 8'h00);
    send_edit(OP_DELETE, 0, 0, 8'h00);
    send_edit(OP_READ, 0, 0, 8'h00);
    send_edit(OP_READ, 1, 0, 8'h00);
    send_edit(OP_DELETE, 0, 2, 8'h00);
    send_edit(OP_READ, 0, 0, 8'h00);
    wait_drained();

    // random phases under each idling mode
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = tx_mode[ph];
      rx_stall_pct = rx_mode[ph];
      for (int i = 0; i < PHASE_EDITS; i++) begin
        // long receiver hold while words keep coming
        if (ph == 0 && i == 100) hold_requests++;
        // sender pause until all results are back
        if (ph == 1 && i == 150) wait_drained();
        rand_edit();
      end
      wait_drained();
    end

    // long gap moves over the whole text, edges of the text, then clear it
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_edit(OP_READ, 0, 0, 8'h00);
    send_edit(OP_READ, POS_W'(board.text_len() - 1), 0, 8'h00);
    send_edit(OP_READ, POS_W'(board.text_len() / 2), 0, 8'h00);
    send_edit(OP_READ, POS_W'(board.text_len()), 0, 8'h00);
    send_edit(OP_INSERT, POS_W'(board.text_len() + 1), 0, 8'h42);
    send_edit(OP_INSERT, POS_W'(board.text_len()), 0, 8'h42);
    send_edit(OP_INSERT, 0, 0, 8'h24);
    send_edit(OP_DELETE, POS_W'(board.text_len() - 1), 2, 8'h00);
    send_edit(OP_DELETE, 0, CNT_W'(board.text_len()), 8'h00);
    send_edit(OP_READ, 0, 0, 8'h00);
    wait_drained();

    // let the block settle, then report
    repeat (20) @(posedge clk_i);
    $display("%0d edits sent: %0d inserts, %0d deletes, %0d reads, %0d unknown codes",
             board.edits_seen, board.op_seen[OP_INSERT], board.op_seen[OP_DELETE],
             board.op_seen[OP_READ], board.op_seen[OP_UNKNOWN]);
    $display("%0d result words checked, peak text length %0d, %0d mismatches",
             board.results_seen, board.peak_len, board.mismatches);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
